// ----- sv/sacd_pkg.sv -----
package sacd_pkg;

    localparam int POS_W  = 32;
    localparam int VEL_W  = 16;
    localparam int SIZE_W = 16;
    localparam int DIR_W  = 4;

    localparam logic [DIR_W-1:0] DIR_NORTH = 4'b0001;
    localparam logic [DIR_W-1:0] DIR_EAST  = 4'b0010;
    localparam logic [DIR_W-1:0] DIR_SOUTH = 4'b0100;
    localparam logic [DIR_W-1:0] DIR_WEST  = 4'b1000;

    typedef struct packed {
        logic signed [POS_W-1:0]  mover_x;
        logic signed [POS_W-1:0]  mover_y;
        logic signed [VEL_W-1:0]  mover_vel_x;
        logic signed [VEL_W-1:0]  mover_vel_y;
        logic        [SIZE_W-1:0] mover_width;
        logic        [SIZE_W-1:0] mover_height;
        logic signed [POS_W-1:0]  target_x;
        logic signed [POS_W-1:0]  target_y;
        logic        [SIZE_W-1:0] target_width;
        logic        [SIZE_W-1:0] target_height;
    } req_t;

endpackage

// ----- sv/sacd_req_if.sv -----
interface sacd_req_if;
    logic                               valid;
    logic                               ready;
    logic signed [sacd_pkg::POS_W-1:0]  mover_x;
    logic signed [sacd_pkg::POS_W-1:0]  mover_y;
    logic signed [sacd_pkg::VEL_W-1:0]  mover_vel_x;
    logic signed [sacd_pkg::VEL_W-1:0]  mover_vel_y;
    logic        [sacd_pkg::SIZE_W-1:0] mover_width;
    logic        [sacd_pkg::SIZE_W-1:0] mover_height;
    logic signed [sacd_pkg::POS_W-1:0]  target_x;
    logic signed [sacd_pkg::POS_W-1:0]  target_y;
    logic        [sacd_pkg::SIZE_W-1:0] target_width;
    logic        [sacd_pkg::SIZE_W-1:0] target_height;

    modport source (
        output valid, mover_x, mover_y, mover_vel_x, mover_vel_y, mover_width,
               mover_height, target_x, target_y, target_width, target_height,
        input  ready
    );

    modport sink (
        input  valid, mover_x, mover_y, mover_vel_x, mover_vel_y, mover_width,
               mover_height, target_x, target_y, target_width, target_height,
        output ready
    );
endinterface

// ----- sv/sacd_rsp_if.sv -----
interface sacd_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [sacd_pkg::DIR_W-1:0]       hit_directions;

    modport source (
        output valid, hit_directions,
        input  ready
    );

    modport sink (
        input  valid, hit_directions,
        output ready
    );
endinterface

// ----- sv/sacd_core.sv -----
module sacd_core #(
    parameter int FRACTION_BITS = 4
) (
    input  sacd_pkg::req_t              req,
    output logic [sacd_pkg::DIR_W-1:0]  hit_directions
);

    localparam int HALF_W   = sacd_pkg::SIZE_W - 1 + FRACTION_BITS;
    localparam int WIDE_W   = (HALF_W + 1 > sacd_pkg::POS_W) ? HALF_W + 1 : sacd_pkg::POS_W;
    localparam int CORNER_W = WIDE_W + 2;

    typedef logic signed [CORNER_W-1:0] corner_t;

    function automatic logic strictly_between(corner_t p, corner_t lo, corner_t hi);
        return (p > lo) && (p < hi);
    endfunction

    logic [HALF_W-1:0] mhw_u, mhh_u, thw_u, thh_u;
    corner_t mx, my, vx, vy, tx, ty, mhw, mhh, thw, thh;
    corner_t t_ax, t_ay, t_bx, t_by;
    corner_t sax, say, sbx, sby;
    corner_t ax, ay, bx, by;
    logic aax, aay, bbx, bby, alx, aly, hit;
    logic xok, yok;

    assign mhw_u = HALF_W'(req.mover_width  >> 1) << FRACTION_BITS;
    assign mhh_u = HALF_W'(req.mover_height >> 1) << FRACTION_BITS;
    assign thw_u = HALF_W'(req.target_width  >> 1) << FRACTION_BITS;
    assign thh_u = HALF_W'(req.target_height >> 1) << FRACTION_BITS;

    assign mhw = CORNER_W'($signed({1'b0, mhw_u}));
    assign mhh = CORNER_W'($signed({1'b0, mhh_u}));
    assign thw = CORNER_W'($signed({1'b0, thw_u}));
    assign thh = CORNER_W'($signed({1'b0, thh_u}));

    assign mx = CORNER_W'(req.mover_x);
    assign my = CORNER_W'(req.mover_y);
    assign vx = CORNER_W'(req.mover_vel_x);
    assign vy = CORNER_W'(req.mover_vel_y);
    assign tx = CORNER_W'(req.target_x);
    assign ty = CORNER_W'(req.target_y);

    assign t_ax = tx - thw;
    assign t_ay = ty - thh;
    assign t_bx = tx + thw;
    assign t_by = ty + thh;

    // mover at rest
    assign sax = mx - mhw;
    assign say = my - mhh;
    assign sbx = mx + mhw;
    assign sby = my + mhh;

    // mover after one step of velocity
    assign ax = sax + vx;
    assign ay = say + vy;
    assign bx = sbx + vx;
    assign by = sby + vy;

    always_comb
    begin
        aax = strictly_between(ax, t_ax, t_bx);
        aay = strictly_between(ay, t_ay, t_by);
        bbx = strictly_between(bx, t_ax, t_bx);
        bby = strictly_between(by, t_ay, t_by);
        alx = (ax == t_ax) || (bx == t_bx);
        aly = (ay == t_ay) || (by == t_by);

        hit = (aax && bby) || (aay && bbx) || (aax && aay) || (bbx && bby)
            || (alx && (aay || bby)) || (aly && (aax || bbx)) || (alx && aly);

        xok = strictly_between(sax, t_ax, t_bx) || strictly_between(sbx, t_ax, t_bx)
            || (sax == t_ax) || (sbx == t_bx);
        yok = strictly_between(say, t_ay, t_by) || strictly_between(sby, t_ay, t_by)
            || (say == t_ay) || (sby == t_by);

        hit_directions = '0;
        if (hit)
        begin
            if (!req.mover_vel_x[sacd_pkg::VEL_W-1] && (req.mover_vel_x != '0) && yok)
                hit_directions = hit_directions | sacd_pkg::DIR_EAST;
            if (req.mover_vel_x[sacd_pkg::VEL_W-1] && yok)
                hit_directions = hit_directions | sacd_pkg::DIR_WEST;
            if (!req.mover_vel_y[sacd_pkg::VEL_W-1] && (req.mover_vel_y != '0) && xok)
                hit_directions = hit_directions | sacd_pkg::DIR_NORTH;
            if (req.mover_vel_y[sacd_pkg::VEL_W-1] && xok)
                hit_directions = hit_directions | sacd_pkg::DIR_SOUTH;
        end
    end

endmodule

// ----- sv/swept_aabb_collision_direction.sv -----
// Swept box collision direction. Takes one request per cycle while the
// response side keeps up and returns one 4-bit side mask (north, east, south,
// west) per request, in order. The request is captured in an input register,
// the corner sums and edge compares run in one combinational pass, and the
// mask lands in an output register. Under backpressure the input register
// still fills, and the request side stalls once both registers hold a
// request.
module swept_aabb_collision_direction #(
    parameter int FRACTION_BITS = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    sacd_req_if.sink     req,
    sacd_rsp_if.source   rsp
);

    logic                        s1_valid_reg, s1_valid_next;
    sacd_pkg::req_t              s1_data_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [sacd_pkg::DIR_W-1:0]  out_dirs_reg;
    logic [sacd_pkg::DIR_W-1:0]  dirs;
    logic                        s2_ready, s1_ready;
    sacd_pkg::req_t              req_data;

    assign s2_ready  = !out_valid_reg || rsp.ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign req.ready = s1_ready;

    assign req_data.mover_x       = req.mover_x;
    assign req_data.mover_y       = req.mover_y;
    assign req_data.mover_vel_x   = req.mover_vel_x;
    assign req_data.mover_vel_y   = req.mover_vel_y;
    assign req_data.mover_width   = req.mover_width;
    assign req_data.mover_height  = req.mover_height;
    assign req_data.target_x      = req.target_x;
    assign req_data.target_y      = req.target_y;
    assign req_data.target_width  = req.target_width;
    assign req_data.target_height = req.target_height;

    sacd_core #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_core (
        .req            (s1_data_reg),
        .hit_directions (dirs)
    );

    always_comb
    begin
        s1_valid_next  = s1_ready ? req.valid : s1_valid_reg;
        out_valid_next = s2_ready ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && req.valid)
            s1_data_reg <= req_data;
        if (s2_ready && s1_valid_reg)
            out_dirs_reg <= dirs;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.hit_directions = out_dirs_reg;

endmodule
